// ===== hw/rtl/swrtt_pkg.sv =====
// shared types and constants of the sliding window rtt controller
package swrtt_pkg;

  // item command codes
  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TIMER = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_MAX  = 2'd0;
  localparam logic [1:0] REG_SLOW_THR    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_CAP = 2'd2;

  // reset values
  localparam logic [9:0]  WINDOW_MAX_RST  = 10'd300;
  localparam logic [9:0]  SLOW_THR_RST    = 10'd51;
  localparam logic [15:0] TIMEOUT_CAP_RST = 16'd1000;
  localparam logic [31:0] RTT_RST         = 32'd500;
  localparam logic [31:0] DEV_RST         = 32'd50;
  localparam logic [31:0] TIMEOUT_RST     = 32'd700;

  // divide-by-five unit: eight dividend bits per step, five steps
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 5;
  localparam int DIV_W     = DIV_BITS * DIV_STEPS;
  localparam int DIV_CNT_W = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ACKRD,
    S_EST,
    S_DIV,
    S_COMMIT,
    S_CLOSE,
    S_FINISH
  } swrtt_state_t;

  typedef struct packed {
    logic [9:0]  window_max;
    logic [9:0]  slow_threshold;
    logic [15:0] timeout_cap_ms;
  } swrtt_cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic send;
    logic timer;
    logic ignore;
    logic mark;
    logic est;
    logic div_step;
    logic commit;
    logic close;
  } swrtt_dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] cmd_code;
    logic       ack_ok;
    logic       slot_acked;
    logic       resent;
    logic       div_last;
    logic       all_acked;
  } swrtt_dp_stat_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] seq_assigned;
    logic [31:0] rtt_ms;
    logic [31:0] deviation_ms;
    logic [31:0] timeout_ms;
    logic [9:0]  window_now;
    logic        collecting;
    logic        window_closed;
    logic [9:0]  resend_count;
  } swrtt_res_t;

endpackage

// ===== hw/rtl/sliding_window_rtt_controller_unit.sv =====
// top level: register port, output item register, controller and datapath
//
// Sender-side sliding window controller with round trip time estimation.
// Input items (cmd, now_ms, ack_seq) are taken on in_valid with in_stall
// low; each gives exactly one result item on out_valid, held until out_stall
// is low. Items are worked one at a time; a new item is taken while the
// previous result still waits in the output register.
// Sends, timer expiries, out-of-window acks and unused commands go from the
// check state straight to the finish state; an in-window ack first reads its
// slot word, then a duplicate finishes, an ack on a resent slot goes to the
// close state, and any other ack runs the estimate, divide and commit states.
// The estimate update runs through the registered read of the slot memory and
// the divide-by-five unit, eight bits a cycle.
// If the receiver stalls, a finished result waits in the controller and
// in_stall stays high until the output register is free.
// Synchronous reset restores the window to size one, the estimates to
// rtt 500, deviation 50, timeout 700 and the registers to their defaults;
// no clearing pass is needed. The user must write the registers through the APB
// port only while the block is idle; the block itself does not enforce this.
module sliding_window_rtt_controller_unit #(
  parameter int SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic [31:0] ack_seq,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] seq_assigned,
  output logic [31:0] rtt_ms,
  output logic [31:0] deviation_ms,
  output logic [31:0] timeout_ms,
  output logic [9:0]  window_now,
  output logic        collecting,
  output logic        window_closed,
  output logic [9:0]  resend_count,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swrtt_pkg::*;

  swrtt_cfg_t     cfg;
  swrtt_dp_cmd_t  ctl;
  swrtt_dp_stat_t stat;
  swrtt_res_t     res;
  swrtt_res_t     out_reg;
  logic           out_load;
  logic           out_free;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_max     <= WINDOW_MAX_RST;
      cfg.slow_threshold <= SLOW_THR_RST;
      cfg.timeout_cap_ms <= TIMEOUT_CAP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WINDOW_MAX:  cfg.window_max     <= pwdata[9:0];
        REG_SLOW_THR:    cfg.slow_threshold <= pwdata[9:0];
        REG_TIMEOUT_CAP: cfg.timeout_cap_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_MAX:  prdata = 32'(cfg.window_max);
      REG_SLOW_THR:    prdata = 32'(cfg.slow_threshold);
      REG_TIMEOUT_CAP: prdata = 32'(cfg.timeout_cap_ms);
      default:         prdata = '0;
    endcase
  end

  swrtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_stall (in_stall),
    .out_load (out_load),
    .ctl      (ctl)
  );

  swrtt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ctl     (ctl),
    .cmd     (cmd),
    .now_ms  (now_ms),
    .ack_seq (ack_seq),
    .stat    (stat),
    .res     (res)
  );

  // output item register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res;
    end
  end

  assign status        = out_reg.status;
  assign seq_assigned  = out_reg.seq_assigned;
  assign rtt_ms        = out_reg.rtt_ms;
  assign deviation_ms  = out_reg.deviation_ms;
  assign timeout_ms    = out_reg.timeout_ms;
  assign window_now    = out_reg.window_now;
  assign collecting    = out_reg.collecting;
  assign window_closed = out_reg.window_closed;
  assign resend_count  = out_reg.resend_count;

endmodule

// ===== hw/rtl/swrtt_ctrl.sv =====
// controller state machine sequencing one item through the datapath
module swrtt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_free,
  input  swrtt_pkg::swrtt_dp_stat_t stat,
  output logic                     in_stall,
  output logic                     out_load,
  output swrtt_pkg::swrtt_dp_cmd_t  ctl
);
  import swrtt_pkg::*;

  swrtt_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat.cmd_code)
          CMD_SEND: begin
            ctl.send   = 1'b1;
            state_next = S_FINISH;
          end
          CMD_TIMER: begin
            ctl.timer  = 1'b1;
            state_next = S_FINISH;
          end
          CMD_ACK: begin
            if (stat.ack_ok) begin
              state_next = S_ACKRD;
            end else begin
              ctl.ignore = 1'b1;
              state_next = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_ACKRD: begin
        // slot word is back from memory
        if (stat.slot_acked) begin
          ctl.ignore = 1'b1;
          state_next = S_FINISH;
        end else begin
          ctl.mark   = 1'b1;
          state_next = stat.resent ? S_CLOSE : S_EST;
        end
      end
      S_EST: begin
        ctl.est    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        ctl.close  = stat.all_acked;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/swrtt_dp.sv =====
// datapath: window counters, slot memory, estimators and divide-by-five unit
module swrtt_dp #(
  parameter int SLOTS = 512
) (
  input  logic                     clk,
  input  logic                     rst,
  input  swrtt_pkg::swrtt_cfg_t     cfg,
  input  swrtt_pkg::swrtt_dp_cmd_t  ctl,
  input  logic [1:0]               cmd,
  input  logic [31:0]              now_ms,
  input  logic [31:0]              ack_seq,
  output swrtt_pkg::swrtt_dp_stat_t stat,
  output swrtt_pkg::swrtt_res_t     res
);
  import swrtt_pkg::*;

  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW      = $clog2(SLOTS + 1);
  localparam int LIM_CAP = (SLOTS < 1023) ? SLOTS : 1023;

  // item registers
  logic [1:0]  item_cmd;
  logic [31:0] item_now;
  logic [31:0] item_ack;

  // window and estimator state
  logic [31:0]   next_seq;
  logic [31:0]   window_base;
  logic [9:0]    win_size;
  logic [SW-1:0] slots_used;
  logic [SW-1:0] acks_counted;
  logic          collecting_flag;
  logic          loss_flag;
  logic [31:0]   rtt_est;
  logic [31:0]   dev_est;
  logic [31:0]   timeout_reg;

  // per-item result
  logic [1:0]  res_status;
  logic [31:0] res_seq;
  logic [9:0]  res_resend;
  logic        res_closed;

  // slot memory: {acked, sent time}
  logic [32:0]   slot_mem [SLOTS];
  logic [32:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [32:0]   mem_wdata;

  // estimator working registers
  logic [31:0]          sample_r;
  logic [31:0]          dev_pend;
  logic [DIV_W-1:0]     div_reg;
  logic [2:0]           div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  // combinational terms
  logic [31:0]   off;
  logic [AW-1:0] off_idx;
  logic          ack_ok;
  logic          send_ok;
  logic [SW-1:0] slots_inc;
  logic          fill_done;
  logic [SW-1:0] resend_n;
  logic [32:0]   to_dbl;
  logic [32:0]   to_cap;
  logic [31:0]   diff;
  logic [33:0]   dev_sum;
  logic [34:0]   dividend;
  logic [2:0]    step_rem;
  logic [3:0]    step_t;
  logic [DIV_BITS-1:0] step_q;
  logic [34:0]   to_sum;
  logic [31:0]   to_new;
  logic [9:0]    lim;
  logic [10:0]   grow;
  logic [9:0]    ws_new;

  // window membership and fill checks
  assign off       = item_ack - window_base;
  assign off_idx   = off[AW-1:0];
  assign ack_ok    = collecting_flag && (off < 32'(win_size)) && (off < 32'(slots_used));
  assign send_ok   = !collecting_flag && (slots_used < SW'(SLOTS));
  assign slots_inc = slots_used + SW'(1);
  assign fill_done = 11'(slots_inc) >= {1'b0, win_size};
  assign resend_n  = slots_used - acks_counted;

  // timer doubling against the cap
  assign to_dbl = {timeout_reg, 1'b0};
  assign to_cap = 33'(cfg.timeout_cap_ms);

  // deviation and rtt dividend from the stored sample
  assign diff     = (sample_r >= rtt_est) ? (sample_r - rtt_est) : (rtt_est - sample_r);
  assign dev_sum  = {1'b0, dev_est, 1'b0} + 34'(dev_est) + 34'(diff);
  assign dividend = 35'({rtt_est, 2'b00}) + 35'(sample_r);

  // one step of the divide by five: eight restoring bits
  always_comb begin
    step_rem = div_rem;
    step_t   = '0;
    step_q   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      step_t = {step_rem, div_reg[DIV_W-1-i]};
      if (step_t >= 4'd5) begin
        step_t = step_t - 4'd5;
        step_q[DIV_BITS-1-i] = 1'b1;
      end
      step_rem = step_t[2:0];
    end
  end

  // new timeout from the quotient, saturated
  assign to_sum = 35'(div_reg[31:0]) + {1'b0, dev_pend, 2'b00};
  assign to_new = (to_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : to_sum[31:0];

  // window resize at close
  always_comb begin
    lim = (cfg.window_max > 10'(LIM_CAP)) ? 10'(LIM_CAP) : cfg.window_max;
    if (lim == 10'd0) begin
      lim = 10'd1;
    end
    grow = (win_size >= cfg.slow_threshold) ? (11'(win_size) + 11'd1)
                                            : {win_size, 1'b0};
    if (loss_flag) begin
      ws_new = (win_size > 10'd1) ? (win_size - 10'd1) : win_size;
    end else if (win_size >= lim) begin
      ws_new = lim;
    end else if (grow > 11'(lim)) begin
      ws_new = lim;
    end else begin
      ws_new = grow[9:0];
    end
  end

  // slot memory ports
  assign mem_we    = (ctl.send && send_ok) || ctl.mark;
  assign mem_waddr = ctl.mark ? off_idx : slots_used[AW-1:0];
  assign mem_wdata = ctl.mark ? {1'b1, rd_data[31:0]} : {1'b0, item_now};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_mem[off_idx];
  end

  // item capture and estimator working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd <= cmd;
      item_now <= now_ms;
      item_ack <= ack_seq;
    end
    if (ctl.mark) begin
      sample_r <= item_now - rd_data[31:0];
    end
    if (ctl.est) begin
      dev_pend <= dev_sum[33:2];
      div_reg  <= DIV_W'(dividend);
      div_rem  <= 3'd0;
      div_cnt  <= '0;
    end else if (ctl.div_step) begin
      div_reg  <= {div_reg[DIV_W-DIV_BITS-1:0], step_q};
      div_rem  <= step_rem;
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // window state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq        <= '0;
      window_base     <= '0;
      win_size        <= 10'd1;
      slots_used      <= '0;
      acks_counted    <= '0;
      collecting_flag <= 1'b0;
      loss_flag       <= 1'b0;
      rtt_est         <= RTT_RST;
      dev_est         <= DEV_RST;
      timeout_reg     <= TIMEOUT_RST;
      res_status      <= ST_OK;
      res_seq         <= '0;
      res_resend      <= '0;
      res_closed      <= 1'b0;
    end else begin
      if (ctl.load) begin
        res_status <= ST_OK;
        res_seq    <= '0;
        res_resend <= '0;
        res_closed <= 1'b0;
      end
      if (ctl.send) begin
        if (!send_ok) begin
          res_status <= ST_REFUSED;
        end else begin
          res_seq    <= next_seq;
          next_seq   <= next_seq + 32'd1;
          slots_used <= slots_inc;
          if (fill_done) begin
            collecting_flag <= 1'b1;
            acks_counted    <= '0;
            loss_flag       <= 1'b0;
          end
        end
      end
      if (ctl.timer && collecting_flag) begin
        res_resend  <= 10'(resend_n);
        loss_flag   <= 1'b1;
        timeout_reg <= (to_dbl < to_cap) ? to_dbl[31:0] : 32'(cfg.timeout_cap_ms);
      end
      if (ctl.ignore) begin
        res_status <= ST_IGNORED;
      end
      if (ctl.mark) begin
        acks_counted <= acks_counted + SW'(1);
      end
      if (ctl.commit) begin
        rtt_est     <= div_reg[31:0];
        dev_est     <= dev_pend;
        timeout_reg <= to_new;
      end
      if (ctl.close) begin
        window_base     <= window_base + 32'(slots_used);
        slots_used      <= '0;
        acks_counted    <= '0;
        collecting_flag <= 1'b0;
        loss_flag       <= 1'b0;
        win_size        <= ws_new;
        res_closed      <= 1'b1;
      end
    end
  end

  // status to the controller
  assign stat.cmd_code   = item_cmd;
  assign stat.ack_ok     = ack_ok;
  assign stat.slot_acked = rd_data[32];
  assign stat.resent     = loss_flag;
  assign stat.div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.all_acked  = (acks_counted >= slots_used);

  // result fields
  assign res.status        = res_status;
  assign res.seq_assigned  = res_seq;
  assign res.rtt_ms        = rtt_est;
  assign res.deviation_ms  = dev_est;
  assign res.timeout_ms    = timeout_reg;
  assign res.window_now    = win_size;
  assign res.collecting    = collecting_flag;
  assign res.window_closed = res_closed;
  assign res.resend_count  = res_resend;

endmodule

// ===== tb/sliding_window_rtt_controller_unit_test.sv =====
// self-checking testbench for the sliding window rtt controller with a clocked driver and monitor
module sliding_window_rtt_controller_unit_test;
  import swrtt_pkg::*;

  localparam int SLOT_COUNT = 512;

  // command value with no meaning, must leave the window alone
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [31:0] ack;
  } ctl_item_t;

  // clock, reset and block inputs
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [1:0]  cmd = CMD_SEND;
  logic [31:0] now_ms = '0;
  logic [31:0] ack_seq = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] seq_assigned;
  logic [31:0] rtt_ms;
  logic [31:0] deviation_ms;
  logic [31:0] timeout_ms;
  logic [9:0]  window_now;
  logic        collecting;
  logic        window_closed;
  logic [9:0]  resend_count;
  logic [31:0] prdata;
  logic        pready;

  sliding_window_rtt_controller_unit #(.SLOTS(SLOT_COUNT)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .now_ms(now_ms), .ack_seq(ack_seq),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .seq_assigned(seq_assigned), .rtt_ms(rtt_ms),
    .deviation_ms(deviation_ms), .timeout_ms(timeout_ms), .window_now(window_now),
    .collecting(collecting), .window_closed(window_closed), .resend_count(resend_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the window controller state
  logic [9:0]  m_wmax = WINDOW_MAX_RST;
  logic [9:0]  m_thr = SLOW_THR_RST;
  logic [15:0] m_cap = TIMEOUT_CAP_RST;
  logic [31:0] m_next_seq = '0;
  logic [31:0] m_base = '0;
  logic [9:0]  m_size = 10'd1;
  logic [9:0]  m_used = '0;
  logic [9:0]  m_acks = '0;
  bit          m_coll = 1'b0;
  bit          m_loss = 1'b0;
  logic [31:0] m_rtt = RTT_RST;
  logic [31:0] m_dev = DEV_RST;
  logic [31:0] m_tout = TIMEOUT_RST;
  logic [31:0] m_sent [SLOT_COUNT];
  bit          m_acked [SLOT_COUNT];
  bit          m_resent [SLOT_COUNT];

  ctl_item_t   pending_cmds [$];
  swrtt_res_t  predicted_reports [$];
  ctl_item_t   drv_item;
  int          burst_left = 0;
  int          gap_left = 0;
  int          mismatches = 0;
  int          result_idx = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] stamp [SLOT_COUNT];
  logic [5:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  // next state and result of the window controller for one item
  function automatic swrtt_res_t window_step(input ctl_item_t it);
    swrtt_res_t  r;
    logic [31:0] off;
    logic [31:0] sample;
    logic [31:0] dif32;
    logic [63:0] dv;
    logic [63:0] rt;
    logic [63:0] to;
    logic [63:0] dbl;
    int          lim;
    int          sz;
    int          cnt;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_SEND: begin
        if (m_coll || m_used >= SLOT_COUNT) begin
          r.status = ST_REFUSED;
        end else begin
          m_sent[m_used] = it.now;
          m_acked[m_used] = 1'b0;
          m_resent[m_used] = 1'b0;
          r.seq_assigned = m_next_seq;
          m_next_seq = m_next_seq + 32'd1;
          m_used = m_used + 10'd1;
          if (m_used >= m_size) begin
            m_coll = 1'b1;
            m_acks = '0;
            m_loss = 1'b0;
          end
        end
      end
      CMD_ACK: begin
        off = it.ack - m_base;
        if (!m_coll || off >= m_size || off >= m_used || off >= SLOT_COUNT || m_acked[off]) begin
          r.status = ST_IGNORED;
        end else begin
          m_acked[off] = 1'b1;
          m_acks = m_acks + 10'd1;
          // estimates only from slots that were never resent
          if (!m_resent[off]) begin
            sample = it.now - m_sent[off];
            dif32 = (sample >= m_rtt) ? sample - m_rtt : m_rtt - sample;
            dv = ({32'b0, m_dev} * 64'd3 + {32'b0, dif32}) / 64'd4;
            rt = ({32'b0, m_rtt} * 64'd4 + {32'b0, sample}) / 64'd5;
            to = rt + dv * 64'd4;
            m_dev = dv[31:0];
            m_rtt = rt[31:0];
            m_tout = (to > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : to[31:0];
          end
          // all slots acked: slide and resize
          if (m_acks >= m_used) begin
            m_base = m_base + 32'(m_used);
            m_used = '0;
            m_acks = '0;
            m_coll = 1'b0;
            lim = int'(m_wmax);
            if (lim > SLOT_COUNT) lim = SLOT_COUNT;
            if (lim > 1023) lim = 1023;
            if (lim < 1) lim = 1;
            sz = int'(m_size);
            if (m_loss) begin
              if (sz > 1) sz = sz - 1;
            end else if (sz >= lim) begin
              sz = lim;
            end else begin
              if (sz >= m_thr) sz = sz + 1;
              else sz = sz * 2;
              if (sz > lim) sz = lim;
            end
            m_size = 10'(sz);
            m_loss = 1'b0;
            r.window_closed = 1'b1;
          end
        end
      end
      CMD_TIMER: begin
        if (m_coll) begin
          cnt = 0;
          for (int i = 0; i < m_used && i < SLOT_COUNT; i++) begin
            if (!m_acked[i]) begin
              m_resent[i] = 1'b1;
              cnt++;
            end
          end
          m_loss = 1'b1;
          dbl = {32'b0, m_tout} * 64'd2;
          m_tout = (dbl < {48'b0, m_cap}) ? dbl[31:0] : {16'b0, m_cap};
          r.resend_count = 10'(cnt);
        end
      end
      default: ;
    endcase
    r.rtt_ms = m_rtt;
    r.deviation_ms = m_dev;
    r.timeout_ms = m_tout;
    r.window_now = m_size;
    r.collecting = m_coll;
    return r;
  endfunction

  // driver: bursts of items from the pending queue with random gaps
  always @(posedge clk) begin : feed
    bit        taken;
    ctl_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) predicted_reports.push_back(window_step(drv_item));
      if (!in_valid || taken) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          drv_item = nxt;
          cmd <= nxt.cmd;
          now_ms <= nxt.now;
          ack_seq <= nxt.ack;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with a new random mode each time the 6-bit tick counter wraps
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_tick <= '0;
      stall_mode <= '0;
    end else begin
      stall_tick <= stall_tick + 6'd1;
      if (stall_tick == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (stall_tick[3:0] < 4'd9);
      endcase
    end
  end

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s in result %0d: expected %0h, got %0h",
                 what, result_idx, want_v, got_v);
    end
  endtask

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : watch
    swrtt_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none predicted", result_idx);
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("seq_assigned", want.seq_assigned, seq_assigned);
        check_field("rtt_ms", want.rtt_ms, rtt_ms);
        check_field("deviation_ms", want.deviation_ms, deviation_ms);
        check_field("timeout_ms", want.timeout_ms, timeout_ms);
        check_field("window_now", 32'(want.window_now), 32'(window_now));
        check_field("collecting", 32'(want.collecting), 32'(collecting));
        check_field("window_closed", 32'(want.window_closed), 32'(window_closed));
        check_field("resend_count", 32'(want.resend_count), 32'(resend_count));
      end
      result_idx++;
    end
  end

  task automatic push_item(input logic [1:0] c, input logic [31:0] t, input logic [31:0] a);
    ctl_item_t it;
    it.cmd = c;
    it.now = t;
    it.ack = a;
    pending_cmds.push_back(it);
  endtask

  // an item that the window should ignore or refuse, sends only while collecting
  task automatic push_noise(input bit allow_send);
    case ($urandom_range(0, 5))
      0: push_item(CMD_ACK, $urandom, $urandom);
      1: push_item(CMD_ACK, clock_ms, m_base + 32'(m_size) + $urandom_range(0, 3));
      2: push_item(CMD_ACK, clock_ms, m_base - 1 - $urandom_range(0, 3));
      3: push_item(CMD_SPARE, $urandom, $urandom);
      4: if (allow_send) push_item(CMD_SEND, $urandom, $urandom);
         else push_item(CMD_TIMER, $urandom, $urandom);
      default: if (!allow_send) push_item(CMD_TIMER, $urandom, $urandom);
               else push_item(CMD_SPARE, $urandom, $urandom);
    endcase
  endtask

  // every item so far has been taken, so the shadow state is current
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic wait_quiet();
    wait_drained();
    while (predicted_reports.size() != 0) @(negedge clk);
  endtask

  // one full window: fill it, then ack every slot in random order with noise
  task automatic build_round(output int made);
    int          first;
    int          n_slots;
    int          k;
    int          tmp;
    int          timer_a;
    int          timer_b;
    int          order [$];
    logic [31:0] smp;
    made = 0;
    first = int'(m_used);
    if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FF00;
    for (int i = 0; i < first; i++) stamp[i] = m_sent[i];
    if (!m_coll) begin
      n_slots = int'((m_size > m_used) ? m_size : m_used);
      for (int i = first; i < n_slots; i++) begin
        if ($urandom_range(0, 7) == 0) push_noise(1'b0);
        stamp[i] = clock_ms;
        push_item(CMD_SEND, clock_ms, $urandom);
        clock_ms = clock_ms + $urandom_range(0, 40);
        made++;
      end
    end else begin
      n_slots = int'(m_used);
    end
    for (int i = 0; i < n_slots; i++)
      if (!(i < first && m_acked[i])) order.push_back(i);
    // shuffle the ack order
    for (int i = order.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    timer_a = -1;
    timer_b = -1;
    if (order.size() != 0) begin
      if ($urandom_range(0, 2) == 0) timer_a = $urandom_range(0, order.size() - 1);
      if ($urandom_range(0, 5) == 0) timer_b = $urandom_range(0, order.size() - 1);
    end
    for (int j = 0; j < order.size(); j++) begin
      if (j == timer_a || j == timer_b) push_item(CMD_TIMER, clock_ms, $urandom);
      if ($urandom_range(0, 7) == 0) push_noise(1'b1);
      if (j > 0 && $urandom_range(0, 9) == 0)
        push_item(CMD_ACK, clock_ms, m_base + order[$urandom_range(0, j - 1)]);
      case ($urandom_range(0, 19))
        0: smp = $urandom;
        1: smp = '0;
        default: smp = $urandom_range(10, 1500);
      endcase
      push_item(CMD_ACK, stamp[order[j]] + smp, m_base + order[j]);
    end
    // a late duplicate after the window has slid
    if (order.size() != 0 && $urandom_range(0, 3) == 0)
      push_item(CMD_ACK, clock_ms, m_base + order[0]);
    made += order.size();
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read_check(input logic [1:0] idx, input logic [31:0] want_v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d reads %0h, expected %0h", idx, prdata, want_v);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // idle block: new settings, then random windows until the budget is spent
  task automatic run_phase(input logic [9:0] wmax, input logic [9:0] thr,
                           input logic [15:0] cap, input int budget);
    int count;
    int made;
    wait_quiet();
    repeat (4) @(posedge clk);
    reg_write(REG_WINDOW_MAX, {22'b0, wmax});
    reg_write(REG_SLOW_THR, {22'b0, thr});
    reg_write(REG_TIMEOUT_CAP, {16'b0, cap});
    m_wmax = wmax;
    m_thr = thr;
    m_cap = cap;
    reg_read_check(REG_WINDOW_MAX, {22'b0, wmax});
    reg_read_check(REG_SLOW_THR, {22'b0, thr});
    reg_read_check(REG_TIMEOUT_CAP, {16'b0, cap});
    clock_ms = $urandom;
    count = 0;
    while (count < budget) begin
      wait_drained();
      build_round(made);
      count += made;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: idle commands, extremes of time, timers, duplicates, wraps
    push_item(CMD_ACK, 32'd0, 32'd0);
    push_item(CMD_TIMER, 32'd0, 32'd0);
    push_item(CMD_SPARE, 32'd0, 32'd0);
    push_item(CMD_SEND, 32'd0, 32'd0);
    push_item(CMD_SEND, 32'd7, 32'd0);
    push_item(CMD_ACK, 32'd9, 32'd5);
    push_item(CMD_ACK, 32'hFFFF_FFFF, 32'd0);
    push_item(CMD_ACK, 32'd10, 32'd0);
    push_item(CMD_SEND, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    push_item(CMD_SEND, 32'd5, 32'd0);
    push_item(CMD_TIMER, 32'd20, 32'd0);
    push_item(CMD_ACK, 32'd30, 32'd2);
    push_item(CMD_ACK, 32'd31, 32'd2);
    push_item(CMD_TIMER, 32'd40, 32'd0);
    push_item(CMD_ACK, 32'd50, 32'd1);
    push_item(CMD_SEND, 32'hFFFF_FFF8, 32'd0);
    push_item(CMD_ACK, 32'd8, 32'd3);
    push_item(CMD_ACK, 32'd9, 32'hFFFF_FFFF);
    push_item(CMD_SEND, 32'd100, 32'd0);
    push_item(CMD_SEND, 32'd130, 32'd0);
    push_item(CMD_ACK, 32'd140, 32'd6);
    push_item(CMD_ACK, 32'd141, 32'd3);
    push_item(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(CMD_SEND, 32'd150, 32'd0);
    // random phases, extremes of the window maximum and the timeout cap among them
    run_phase(10'd300, 10'd51, 16'd1000, 150);
    run_phase(10'd8, 10'd4, 16'hFFFF, 350);
    run_phase(10'd1, 10'd1, 16'd1, 150);
    run_phase(10'd0, 10'd512, 16'd2000, 100);
    run_phase(10'd512, 10'd512, 16'd40000, 250);
    run_phase(10'd1023, 10'd3, 16'd300, 200);
    run_phase(10'd20, 10'd1, 16'hFFFF, 150);
    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("sliding_window_rtt_controller_unit regression: pass");
    end else begin
      $display("sliding_window_rtt_controller_unit regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("sliding_window_rtt_controller_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/swrtt_pkg.sv
hw/rtl/swrtt_ctrl.sv
hw/rtl/swrtt_dp.sv
hw/rtl/sliding_window_rtt_controller_unit.sv
tb/sliding_window_rtt_controller_unit_test.sv
